FILE: hdl/cbad_pkg.sv
// Shared types and constants for the console bus address decoder.
// No dependencies; imported by console_bus_address_decoder.
package cbad_pkg;

    localparam int unsigned RamBanksDefault  = 32;
    localparam int unsigned BiosBanksDefault = 8;

    localparam int unsigned InDataW  = 72;
    localparam int unsigned OutDataW = 96;

    typedef logic [2:0] target_t;

    localparam target_t TargetNone    = 3'd0;
    localparam target_t TargetRam     = 3'd1;
    localparam target_t TargetPort    = 3'd2;
    localparam target_t TargetScratch = 3'd3;
    localparam target_t TargetHwReg   = 3'd4;
    localparam target_t TargetBios    = 3'd5;

    localparam logic [1:0] SizeByte = 2'd0;
    localparam logic [1:0] SizeHalf = 2'd1;

    localparam logic [15:0] SegPort     = 16'h1f00;
    localparam logic [15:0] SegIo       = 16'h1f80;
    localparam logic [31:0] HwRegStart  = 32'h1f80_1000;
    localparam logic [12:0] RamIdxLimit = 13'h0080;
    localparam logic [12:0] BiosIdxBase = 13'h1fc0;
    localparam logic [2:0]  BaseKseg0   = 3'b000;
    localparam logic [2:0]  BaseKseg1   = 3'b100;
    localparam logic [2:0]  BaseKseg2   = 3'b101;

    localparam logic [31:0] CtrlAddr    = 32'hfffe_0130;
    localparam logic [31:0] IsoEnterA   = 32'h0000_0800;
    localparam logic [31:0] IsoEnterB   = 32'h0000_0804;
    localparam logic [31:0] IsoLeaveA   = 32'h0000_0000;
    localparam logic [31:0] IsoLeaveB   = 32'h0001_e988;

    typedef struct packed {
        logic [1:0]  access_size;
        logic [31:0] bus_address;
        logic [31:0] store_value;
        logic        kind;
    } access_t;

    typedef struct packed {
        logic        cycle_cost;
        logic        icache_flush;
        logic [31:0] invalidate_address;
        logic        invalidate_request;
        logic [31:0] store_data;
        logic        read_zero;
        logic        do_store;
        logic [20:0] region_offset;
        target_t     target;
    } result_t;

endpackage

FILE: hdl/console_bus_address_decoder.sv
// Top level of the console bus address decoder: input register, decode, result register.
// Depends on cbad_pkg.
//
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tuser kind, s_tdata size, address, store value
//  m_      | out | m_tvalid/m_tready  | m_tdata target, offset, store, zero, data, inval, flush, cost
//
// One item per cycle while m_ is not stalled; an accepted item passes the input register and
// then the result register around the decode before it is on m_.
// aresetn (synchronous, active low) empties both stages and clears isolation.
// A stalled m_ side holds the result; s_ keeps accepting until both stages are full.
module console_bus_address_decoder #(
    parameter int unsigned RAM_BANKS  = cbad_pkg::RamBanksDefault,
    parameter int unsigned BIOS_BANKS = cbad_pkg::BiosBanksDefault
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [1:0] access_size, [33:2] bus_address, [65:34] store_value, [71:66] zero
    input  logic [cbad_pkg::InDataW-1:0]  s_tdata,
    // [0] kind
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] target, [23:3] region_offset, [24] do_store, [25] read_zero,
    // [57:26] store_data, [58] invalidate_request, [90:59] invalidate_address,
    // [91] icache_flush, [92] cycle_cost, [95:93] zero
    output logic [cbad_pkg::OutDataW-1:0] m_tdata
);
    import cbad_pkg::*;

    logic    in_valid_reg;
    access_t in_reg;
    logic    out_valid_reg;
    result_t out_reg;
    logic    iso_reg;
    logic    iso_next;
    logic    advance;
    result_t res;

    logic [6:0]  ram_bank_lut [128];
    logic [15:0] seg;
    logic [12:0] idx;
    logic [12:0] bios_idx;
    logic        base_ok;
    logic        word;
    logic        is_write;
    logic        writable;

    for (genvar i = 0; i < 128; i++) begin : g_bank_lut
        assign ram_bank_lut[i] = 7'(i % RAM_BANKS);
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutDataW - $bits(result_t)){1'b0}}, out_reg};

    assign seg      = in_reg.bus_address[31:16];
    assign idx      = seg[12:0];
    assign bios_idx = idx - BiosIdxBase;
    assign base_ok  = (seg[15:13] == BaseKseg0) || (seg[15:13] == BaseKseg1)
                   || (seg[15:13] == BaseKseg2);
    assign word     = in_reg.access_size[1];
    assign is_write = in_reg.kind;

    always_comb begin
        res      = '0;
        iso_next = iso_reg;

        if (base_ok && idx < RamIdxLimit) begin
            res.target        = TargetRam;
            res.region_offset = {ram_bank_lut[idx[6:0]][4:0], in_reg.bus_address[15:0]};
        end else if (seg == SegPort) begin
            res.target        = TargetPort;
            res.region_offset = {5'd0, in_reg.bus_address[15:0]};
        end else if (seg == SegIo) begin
            res.target        = (in_reg.bus_address < HwRegStart) ? TargetScratch : TargetHwReg;
            res.region_offset = {5'd0, in_reg.bus_address[15:0]};
        end else if (base_ok && idx >= BiosIdxBase && bios_idx < 13'(BIOS_BANKS)) begin
            res.target        = TargetBios;
            res.region_offset = {bios_idx[4:0], in_reg.bus_address[15:0]};
        end

        res.cycle_cost = is_write || (in_reg.access_size != SizeByte);
        writable = (res.target == TargetPort) || (res.target == TargetRam && !iso_reg);

        if (!is_write) begin
            res.read_zero = (res.target == TargetNone);
        end else begin
            case (in_reg.access_size)
                SizeByte: res.store_data = {24'd0, in_reg.store_value[7:0]};
                SizeHalf: res.store_data = {16'd0, in_reg.store_value[15:0]};
                default:  res.store_data = in_reg.store_value;
            endcase
            if (res.target == TargetScratch || res.target == TargetHwReg) begin
                res.do_store = 1'b1;
            end else if (writable) begin
                res.do_store           = 1'b1;
                res.invalidate_request = 1'b1;
                res.invalidate_address = word ? in_reg.bus_address
                                              : {in_reg.bus_address[31:2], 2'b00};
            end else if (word) begin
                if (in_reg.bus_address != CtrlAddr) begin
                    if (iso_reg) begin
                        res.invalidate_request = 1'b1;
                        res.invalidate_address = in_reg.bus_address;
                    end
                end else if (in_reg.store_value == IsoEnterA
                          || in_reg.store_value == IsoEnterB) begin
                    if (!iso_reg) begin
                        iso_next         = 1'b1;
                        res.icache_flush = 1'b1;
                    end
                end else if (in_reg.store_value == IsoLeaveA
                          || in_reg.store_value == IsoLeaveB) begin
                    iso_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            iso_reg       <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                iso_reg       <= iso_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg.kind        <= s_tuser;
            in_reg.access_size <= s_tdata[1:0];
            in_reg.bus_address <= s_tdata[33:2];
            in_reg.store_value <= s_tdata[65:34];
        end
        if (advance) begin
            out_reg <= res;
        end
    end

    a_flush_enters_isolation: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && res.icache_flush |=> iso_reg)
        else $error("icache flush without entering isolation");

    a_iso_only_on_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(iso_reg))
        else $error("isolation changed without an item");

    a_read_zero_unmapped: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.read_zero |-> !out_reg.do_store
            && out_reg.target == TargetNone && out_reg.store_data == 32'd0)
        else $error("read_zero on a mapped or storing item");

    a_inval_addr_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_reg.invalidate_request |-> out_reg.invalidate_address == 32'd0)
        else $error("invalidate address set without request");

endmodule
